[rtl/sspp_pkg.sv]
package sspp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned IndexW = 9;

  // byte positions within a status packet
  localparam logic [IndexW-1:0] IdxId     = 9'd2;
  localparam logic [IndexW-1:0] IdxLength = 9'd3;
  localparam logic [IndexW-1:0] HdrBytes  = 9'd4;
  localparam logic [ByteW-1:0]  MinLength = 8'd2;

  // tdata is padded to whole bytes
  localparam int unsigned OutDataW = 24;
  localparam int unsigned OutUserW = 2;

  typedef struct packed {
    logic [ByteW-1:0]  data_byte;
    logic [IndexW-1:0] byte_index;
    logic              end_of_packet;
    logic              checksum_error;
    logic              length_error;
  } result_t;

endpackage

[rtl/sspp_framer.sv]
module sspp_framer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  logic [sspp_pkg::ByteW-1:0]  rx_byte_i,
  output sspp_pkg::result_t           result_o
);

  logic [sspp_pkg::IndexW-1:0] position_q, position_d;
  logic [sspp_pkg::IndexW-1:0] total_q, total_d;
  logic [sspp_pkg::ByteW-1:0]  sum_q, sum_d;
  logic                        eop, cerr, lerr;

  always_comb begin
    position_d = position_q;
    total_d    = total_q;
    sum_d      = sum_q;
    eop        = 1'b0;
    cerr       = 1'b0;
    lerr       = 1'b0;
    priority if (position_q < sspp_pkg::IdxId) begin
      position_d = position_q + 9'd1;
    end else if (position_q == sspp_pkg::IdxId) begin
      sum_d      = rx_byte_i;
      position_d = position_q + 9'd1;
    end else if (position_q == sspp_pkg::IdxLength) begin
      if (rx_byte_i < sspp_pkg::MinLength) begin
        lerr       = 1'b1;
        eop        = 1'b1;
        position_d = '0;
        total_d    = '0;
        sum_d      = '0;
      end else begin
        sum_d      = sum_q + rx_byte_i;
        total_d    = {1'b0, rx_byte_i} + sspp_pkg::IdxLength;
        position_d = sspp_pkg::HdrBytes;
      end
    end else if (position_q >= total_q) begin
      // checksum byte: ones' complement of the sum from id on
      eop        = 1'b1;
      cerr       = (rx_byte_i != ~sum_q);
      position_d = '0;
      total_d    = '0;
      sum_d      = '0;
    end else begin
      sum_d      = sum_q + rx_byte_i;
      position_d = position_q + 9'd1;
    end
  end

  always_comb begin
    result_o.data_byte      = rx_byte_i;
    result_o.byte_index     = position_q;
    result_o.end_of_packet  = eop;
    result_o.checksum_error = cerr;
    result_o.length_error   = lerr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q <= '0;
      total_q    <= '0;
      sum_q      <= '0;
    end else if (fire_i) begin
      position_q <= position_d;
      total_q    <= total_d;
      sum_q      <= sum_d;
    end
  end

endmodule

[rtl/servo_status_packet_parser.sv]
// Servo status packet parser: one received byte in, one annotated byte out.
// An accepted byte passes through the input reg, then the result reg, to output valid.
// Throughput: one item per cycle; both stages stall only on downstream tready.
// Reset (rst_ni low, async): pipeline emptied, packet position, length and
// running sum cleared, so the next byte is taken as header byte 0.
module servo_status_packet_parser (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [sspp_pkg::ByteW-1:0]        s_axis_tdata_i,  // [7:0] rx_byte
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [sspp_pkg::OutDataW-1:0]     m_axis_tdata_o,  // [7:0] data_byte,
                                                              // [16:8] byte_index
  output logic                              m_axis_tlast_o,  // end_of_packet
  output logic [sspp_pkg::OutUserW-1:0]     m_axis_tuser_o   // [0] checksum_error,
                                                              // [1] length_error
);

  logic                        in_valid_q;
  logic [sspp_pkg::ByteW-1:0]  in_byte_q;
  logic                        out_valid_q;
  sspp_pkg::result_t           out_q;
  sspp_pkg::result_t           result;
  logic                        out_ready;
  logic                        fire;

  assign out_ready       = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && out_ready;
  assign s_axis_tready_o = !in_valid_q || out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  sspp_framer u_framer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .rx_byte_i (in_byte_q),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_q.byte_index, out_q.data_byte};
  assign m_axis_tlast_o  = out_q.end_of_packet;
  assign m_axis_tuser_o  = {out_q.length_error, out_q.checksum_error};

  // a length error always sits on the length byte and closes the packet
  a_lerr_on_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1]) |->
      (m_axis_tlast_o && m_axis_tdata_o[16:8] == sspp_pkg::IdxLength))
    else $error("length error off the length byte");

  // a checksum error only on a closing byte past the header
  a_cerr_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |->
      (m_axis_tlast_o && m_axis_tdata_o[16:8] >= sspp_pkg::HdrBytes))
    else $error("checksum error on a non-final byte");

  // the item after a closing item restarts at index 0
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && result.end_of_packet) |=> (u_framer.result_o.byte_index == '0))
    else $error("packet did not restart");

  // byte index never runs past the longest packet
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[16:8] <= 9'd258))
    else $error("byte index out of range");

endmodule
